// ----- design/cnlc_pkg.sv -----
// ----------------------------------------------------------------------------
// cnlc_pkg: shared types and constants of the card number classifier
// digit chain sizing, verdict codes, control structs and luhn helper
// ----------------------------------------------------------------------------
package cnlc_pkg;

  localparam int MAX_DIGITS = 19;
  localparam int CARD_W     = 63;
  localparam int IN_TDATA_W = 64;
  localparam int COUNT_W    = 5;
  localparam int OUT_TDATA_W = 8;
  localparam int SEQ_W      = $clog2(CARD_W);
  localparam int DIG_IDX_W  = $clog2(MAX_DIGITS);

  localparam logic [1:0] VERDICT_INVALID    = 2'd0;
  localparam logic [1:0] VERDICT_AMEX       = 2'd1;
  localparam logic [1:0] VERDICT_MASTERCARD = 2'd2;
  localparam logic [1:0] VERDICT_VISA       = 2'd3;

  localparam logic [COUNT_W-1:0] LEN_MIN = COUNT_W'(13);
  localparam logic [COUNT_W-1:0] LEN_MAX = COUNT_W'(16);

  typedef struct packed {
    logic clear;
    logic shift;
    logic drain;
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
  } acc_ctrl_t;

  typedef struct packed {
    logic [1:0]         verdict;
    logic               checksum_ok;
    logic [COUNT_W-1:0] digit_count;
  } result_t;

  // doubled digit with the two product digits summed
  function automatic logic [3:0] luhn_double(input logic [3:0] d);
    logic [4:0] p;
    p = {d, 1'b0};
    if (p > 5'd9) begin
      p = p - 5'd9;
    end
    return p[3:0];
  endfunction

endpackage

// ----- design/card_number_luhn_classifier_core.sv -----
// ----------------------------------------------------------------------------
// card_number_luhn_classifier_core: luhn check and card type of a binary number
// Usage:
//   in_* channel carries one card number per transfer in in_tdata[62:0];
//   bit 63 is ignored. out_* channel returns one result per input transfer.
//   A row of decimal digit cells converts the number bit-serially, most
//   significant bit first, one bit per cycle. The cells then shift their
//   digits down one place per cycle into a serial luhn accumulator. After
//   the drain, once the output register is free, the result is loaded into
//   it, out_tvalid is set and the block returns to idle for the next item.
//   One item is in work at a time; in_tready is high while the block idles,
//   also while a finished result still waits in the output register.
//   If the receiver stalls, the next item completes its work and then holds
//   until the output register is free.
//   Reset (rst_n low, synchronous) returns to idle and drops out_tvalid.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier_core
  import cnlc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // [62:0] card_value, [63] zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // [1:0] verdict, [2] checksum_ok, [7:3] digit_count
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SEQ_W-1:0]   cnt_r, cnt_nxt;
  logic [CARD_W-1:0]  shreg_r, shreg_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            out_res_r, out_res_nxt;

  cell_ctrl_t         cell_ctrl;
  acc_ctrl_t          acc_ctrl;
  result_t            acc_res;
  logic               in_xfer;
  logic               out_free;

  logic [MAX_DIGITS:0]   bit_chain;
  logic [3:0]            digit_q [MAX_DIGITS];
  logic [3:0]            digit_above [MAX_DIGITS];

  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign cell_ctrl.clear = in_xfer;
  assign cell_ctrl.shift = (state_r == ST_CONV);
  assign cell_ctrl.drain = (state_r == ST_DRAIN);
  assign acc_ctrl.clear  = in_xfer;
  assign acc_ctrl.step   = (state_r == ST_DRAIN);

  assign bit_chain[0] = shreg_r[CARD_W-1];

  genvar k;
  generate
    for (k = 0; k < MAX_DIGITS; k++) begin : g_cell
      if (k == MAX_DIGITS - 1) begin : g_top
        assign digit_above[k] = 4'd0;
      end else begin : g_mid
        assign digit_above[k] = digit_q[k+1];
      end
      cnlc_digit_cell u_cell (
        .clk      (clk),
        .ctrl     (cell_ctrl),
        .bit_in   (bit_chain[k]),
        .bit_out  (bit_chain[k+1]),
        .digit_in (digit_above[k]),
        .digit_q  (digit_q[k])
      );
    end
  endgenerate

  cnlc_luhn_acc u_acc (
    .clk    (clk),
    .ctrl   (acc_ctrl),
    .digit  (digit_q[0]),
    .result (acc_res)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    shreg_nxt     = shreg_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          shreg_nxt = in_tdata[CARD_W-1:0];
          cnt_nxt   = '0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        shreg_nxt = {shreg_r[CARD_W-2:0], 1'b0};
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == SEQ_W'(CARD_W - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == SEQ_W'(MAX_DIGITS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_res_nxt   = acc_res;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shreg_r   <= shreg_nxt;
    out_res_r <= out_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.digit_count, out_res_r.checksum_ok, out_res_r.verdict};

endmodule

// ----- design/cnlc_digit_cell.sv -----
// ----------------------------------------------------------------------------
// cnlc_digit_cell: one decimal digit of the conversion chain
// shift-and-add-3 step towards the upper neighbour, digit shift towards the lower
// ----------------------------------------------------------------------------
module cnlc_digit_cell
  import cnlc_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       bit_in,
  output logic       bit_out,
  input  logic [3:0] digit_in,
  output logic [3:0] digit_q
);

  logic [3:0] digit_r;
  logic [3:0] digit_nxt;
  logic [3:0] adj;

  assign adj     = (digit_r >= 4'd5) ? digit_r + 4'd3 : digit_r;
  assign bit_out = adj[3];
  assign digit_q = digit_r;

  always_comb begin
    priority if (ctrl.clear) begin
      digit_nxt = 4'd0;
    end else if (ctrl.shift) begin
      digit_nxt = {adj[2:0], bit_in};
    end else if (ctrl.drain) begin
      digit_nxt = digit_in;
    end else begin
      digit_nxt = digit_r;
    end
  end

  always_ff @(posedge clk) begin
    digit_r <= digit_nxt;
  end

endmodule

// ----- design/cnlc_luhn_acc.sv -----
// ----------------------------------------------------------------------------
// cnlc_luhn_acc: serial luhn sum, digit count and leading digits
// takes one digit each step cycle, least significant first; forms the verdict
// ----------------------------------------------------------------------------
module cnlc_luhn_acc
  import cnlc_pkg::*;
(
  input  logic       clk,
  input  acc_ctrl_t  ctrl,
  input  logic [3:0] digit,
  output result_t    result
);

  logic [3:0]           sum_r, sum_nxt;
  logic [COUNT_W-1:0]   n_r, n_nxt;
  logic [3:0]           prev_r, prev_nxt;
  logic [3:0]           hi_r, hi_nxt;
  logic [3:0]           lo_r, lo_nxt;
  logic [DIG_IDX_W-1:0] idx_r, idx_nxt;
  logic [3:0]           dd;
  logic [4:0]           sum_add;
  logic [3:0]           tens, ones;
  logic                 ok;

  assign dd      = idx_r[0] ? luhn_double(digit) : digit;
  assign sum_add = {1'b0, sum_r} + {1'b0, dd};

  always_comb begin
    sum_nxt  = sum_r;
    n_nxt    = n_r;
    prev_nxt = prev_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    idx_nxt  = idx_r;
    priority if (ctrl.clear) begin
      sum_nxt  = 4'd0;
      n_nxt    = '0;
      prev_nxt = 4'd0;
      hi_nxt   = 4'd0;
      lo_nxt   = 4'd0;
      idx_nxt  = '0;
    end else if (ctrl.step) begin
      sum_nxt  = (sum_add >= 5'd10) ? 4'(sum_add - 5'd10) : sum_add[3:0];
      prev_nxt = digit;
      idx_nxt  = idx_r + 1'b1;
      if (digit != 4'd0) begin
        n_nxt  = COUNT_W'(idx_r) + 1'b1;
        hi_nxt = digit;
        lo_nxt = prev_r;
      end
    end else begin
      sum_nxt = sum_r;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    n_r    <= n_nxt;
    prev_r <= prev_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
    idx_r  <= idx_nxt;
  end

  // a single digit stands alone as the leading pair
  assign tens = (n_r >= COUNT_W'(2)) ? hi_r : 4'd0;
  assign ones = (n_r >= COUNT_W'(2)) ? lo_r : hi_r;
  assign ok   = (sum_r == 4'd0);

  always_comb begin
    result.checksum_ok = ok;
    result.digit_count = n_r;
    priority if (!ok || n_r < LEN_MIN || n_r > LEN_MAX) begin
      result.verdict = VERDICT_INVALID;
    end else if (tens == 4'd3 && (ones == 4'd4 || ones == 4'd7)) begin
      result.verdict = VERDICT_AMEX;
    end else if (tens == 4'd5 && ones >= 4'd1 && ones <= 4'd5) begin
      result.verdict = VERDICT_MASTERCARD;
    end else if (tens == 4'd4) begin
      result.verdict = VERDICT_VISA;
    end else begin
      result.verdict = VERDICT_INVALID;
    end
  end

endmodule

// ----- design/cnlc_checker.sv -----
// ----------------------------------------------------------------------------
// cnlc_checker: port-level checks of the card number classifier
// result consistency, busy after a transfer, reset and output hold
// ----------------------------------------------------------------------------
module cnlc_checker
  import cnlc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  logic [COUNT_W-1:0] cnt;
  logic [1:0]         verdict;

  assign cnt     = out_tdata[OUT_TDATA_W-1:3];
  assign verdict = out_tdata[1:0];

  a_card_needs_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && verdict != VERDICT_INVALID |->
      out_tdata[2] && cnt >= LEN_MIN && cnt <= LEN_MAX)
    else $error("card verdict without luhn pass or valid length");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> cnt <= COUNT_W'(MAX_DIGITS))
    else $error("digit count beyond digit chain");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready && !$rose(out_tvalid))
    else $error("block ready or finished right after an input transfer");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output valid or busy after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind card_number_luhn_classifier_core cnlc_checker u_cnlc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
